// ===== hdl/pls_pkg.sv =====
package pls_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int ENTRY_W        = 64;
    localparam int MUL_STEPS      = 33;
    localparam int DIV_STEPS      = 64;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_COMMIT  = 2'd1;
    localparam logic [1:0] OP_CONVERT = 2'd2;

    localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_CLAMP_ENDS  = 2'd1;
    localparam logic [1:0] CFG_SWAP_AXES   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic start;
        logic div;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

    function automatic logic [32:0] mag33(input logic [32:0] d);
        return d[32] ? (~d + 33'd1) : d;
    endfunction

endpackage

// ===== hdl/pls_table.sv =====
module pls_table #(
    parameter int DEPTH = pls_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [pls_pkg::ENTRY_W-1:0]  wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [pls_pkg::ENTRY_W-1:0]  rdata
);
    import pls_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/pls_arith.sv =====
module pls_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  pls_pkg::arith_cmd_t cmd,
    input  logic [63:0]         opa,
    input  logic [32:0]         opb,
    output pls_pkg::arith_rsp_t rsp,
    output logic [33:0]         res_hi,
    output logic [63:0]         res_lo
);
    import pls_pkg::*;

    // mul: {hi,lo[32:0]} shift-add, multiplier in lo, multiplicand in d
    // div: restoring, remainder in hi, dividend/quotient in lo
    logic [33:0] hi_reg;
    logic [63:0] lo_reg;
    logic [32:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        div_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [33:0] shifted;
    logic [34:0] x_op;
    logic [34:0] y_op;
    logic [34:0] sum;
    logic        ge;

    always_comb
    begin
        shifted = {hi_reg[32:0], lo_reg[63]};
        if (div_reg)
        begin
            x_op = {1'b0, shifted};
            y_op = ~{2'b00, d_reg};
        end
        else
        begin
            x_op = {1'b0, hi_reg};
            y_op = lo_reg[0] ? {2'b00, d_reg} : 35'd0;
        end
        sum = x_op + y_op + {34'd0, div_reg};
        ge  = ~sum[34];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.div ? 7'(DIV_STEPS) : 7'(MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            hi_reg  <= 34'd0;
            lo_reg  <= opa;
            d_reg   <= opb;
            div_reg <= cmd.div;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                hi_reg <= ge ? sum[33:0] : shifted;
                lo_reg <= {lo_reg[62:0], ge};
            end
            else
            begin
                hi_reg <= {1'b0, sum[33:1]};
                lo_reg <= {31'd0, sum[0], lo_reg[32:1]};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign res_hi   = hi_reg;
    assign res_lo   = lo_reg;

endmodule

// ===== hdl/piecewise_linear_table_scaler_core.sv =====
// Piecewise linear table scaler. Breakpoint pairs (point_in, point_out) are written with
// opcode 0, which also drops the committed state. Opcode 1 commits the first point_count
// entries: inputs must be strictly monotonic (either direction) and each segment's span
// product must fit 63 bits; on success the direction, domain and output range are latched,
// on refusal the block stays not ready. Opcode 2 converts a sample: out-of-domain samples
// are rejected or clamped (clamp_ends), the segment is found by a linear scan that reports
// the lower segment on a tie, and the value is interpolated with rounding half away from
// zero. swap_axes at commit selects the inverse map. Configuration writes take effect at
// once and are meant only while no transaction is in flight. Every transaction returns
// exactly one result; the next input is taken after that result is accepted.
// Sequence: a write or rejected request goes straight to the result and the output handshake. A
// commit walks the entries in order: per segment one table read, one check and the 33-step span
// multiply. A convert scans the table reads up to its segment, then runs the 33-step multiply,
// the 64-step divide (same shift-add/subtract unit) and one rounding step.
module piecewise_linear_table_scaler_core #(
    parameter int MAX_POINTS = pls_pkg::MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [3:0]         point_index,
    input  logic signed [31:0] point_in,
    input  logic signed [31:0] point_out,
    input  logic signed [31:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] value,
    output logic [3:0]         segment,
    output logic               in_domain,
    output logic               rising,
    output logic signed [31:0] domain_low,
    output logic signed [31:0] domain_high,
    output logic signed [31:0] range_low,
    output logic signed [31:0] range_high
);
    import pls_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_CM_LOAD  = 12'b000000000010,
        S_CM_CHECK = 12'b000000000100,
        S_CM_MUL   = 12'b000000001000,
        S_CV_LOAD  = 12'b000000010000,
        S_CV_CHECK = 12'b000000100000,
        S_CV_LOAD0 = 12'b000001000000,
        S_CV_GET0  = 12'b000010000000,
        S_CV_MUL   = 12'b000100000000,
        S_CV_DIV   = 12'b001000000000,
        S_CV_ROUND = 12'b010000000000,
        S_RESULT   = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [4:0]  pcount_reg;
    logic        clamp_reg;
    logic        swap_cfg_reg;

    // committed table state
    logic               ready_reg;
    logic               rising_reg;
    logic               cswap_reg;
    logic [4:0]         act_cnt_reg;
    logic signed [31:0] ext_reg [4];

    // working registers
    logic [4:0]         idx_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] pax_reg;
    logic signed [31:0] pay_reg;
    logic signed [31:0] fax_reg;
    logic signed [31:0] mn_reg;
    logic signed [31:0] mx_reg;
    logic signed [31:0] ax1_reg;
    logic signed [31:0] ay1_reg;
    logic signed [31:0] ay0_reg;
    logic [31:0]        qm_reg;
    logic [32:0]        den_reg;
    logic               up_reg;
    logic               neg_reg;

    // result registers
    logic [2:0]         st_reg;
    logic signed [31:0] val_reg;
    logic [3:0]         seg_reg;
    logic               indom_reg;

    logic accept;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // breakpoint store
    logic              tbl_we;
    logic [AW+3:0]     waddr_wide;
    logic [AW+4:0]     raddr_wide;
    logic              rd_en;
    logic [ENTRY_W-1:0] rd_data;

    assign waddr_wide = {{AW{1'b0}}, point_index};
    assign raddr_wide = {{AW{1'b0}}, idx_reg};
    assign tbl_we = accept && (opcode == OP_WRITE)
                    && ({28'd0, point_index} < 32'(MAX_POINTS));
    assign rd_en  = (state_reg == S_CM_LOAD) || (state_reg == S_CV_LOAD)
                    || (state_reg == S_CV_LOAD0);

    pls_table #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (waddr_wide[AW-1:0]),
        .wdata ({point_in, point_out}),
        .re    (rd_en),
        .raddr (raddr_wide[AW-1:0]),
        .rdata (rd_data)
    );

    // axis selection: commit uses the live swap setting, convert the committed one
    logic               use_swap;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    assign use_swap = (state_reg == S_CM_CHECK) ? swap_cfg_reg : cswap_reg;
    assign ax = use_swap ? rd_data[31:0]  : rd_data[63:32];
    assign ay = use_swap ? rd_data[63:32] : rd_data[31:0];

    // shared multiply/divide unit
    arith_cmd_t  ar_cmd;
    arith_rsp_t  ar_rsp;
    logic [63:0] ar_opa;
    logic [32:0] ar_opb;
    logic [33:0] ar_hi;
    logic [63:0] ar_lo;
    logic [65:0] prod;

    pls_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ar_cmd),
        .opa    (ar_opa),
        .opb    (ar_opb),
        .rsp    (ar_rsp),
        .res_hi (ar_hi),
        .res_lo (ar_lo)
    );

    assign prod = {ar_hi[32:0], ar_lo[32:0]};

    // commit segment checks
    logic [32:0] dx;
    logic [32:0] dy;
    logic        up_eff;
    logic        dir_fail;
    logic        cm_last;
    logic        over;

    assign dx = {ax[31], ax} - {pax_reg[31], pax_reg};
    assign dy = {ay[31], ay} - {pay_reg[31], pay_reg};
    assign up_eff   = (idx_reg == 5'd1) ? (!dx[32] && (dx != 33'd0)) : up_reg;
    assign dir_fail = up_eff ? (dx[32] || (dx == 33'd0)) : !dx[32];
    assign cm_last  = (idx_reg == cnt_reg - 5'd1);
    assign over     = |prod[65:63];

    // convert
    logic        in_rng;
    logic        hit;
    logic        cv_last;
    logic [32:0] a_d;
    logic [32:0] dy0;
    logic [32:0] den_d;
    logic        inc;
    logic        cnt_bad;

    assign in_rng  = (sample >= ext_reg[0]) && (sample <= ext_reg[1]);
    assign hit     = rising_reg ? (s_reg <= ax) : (s_reg >= ax);
    assign cv_last = (idx_reg == act_cnt_reg - 5'd1);
    assign a_d     = {s_reg[31], s_reg} - {ax[31], ax};
    assign dy0     = {ay1_reg[31], ay1_reg} - {ay[31], ay};
    assign den_d   = {ax1_reg[31], ax1_reg} - {ax[31], ax};
    assign inc     = ({ar_hi[32:0], 1'b0} >= {1'b0, den_reg});
    assign cnt_bad = (pcount_reg < 5'd2) || ({27'd0, pcount_reg} > 32'(MAX_POINTS));

    always_comb
    begin
        ar_cmd = '0;
        ar_opa = 64'd0;
        ar_opb = 33'd0;
        case (state_reg)
            S_CM_CHECK:
            begin
                ar_cmd.start = (idx_reg != 5'd0) && !dir_fail;
                ar_opa = {31'd0, mag33(dx)};
                ar_opb = mag33(dy);
            end
            S_CV_GET0:
            begin
                ar_cmd.start = 1'b1;
                ar_opa = {31'd0, mag33(a_d)};
                ar_opb = mag33(dy0);
            end
            S_CV_MUL:
            begin
                ar_cmd.start = ar_rsp.done;
                ar_cmd.div   = 1'b1;
                ar_opa = prod[63:0];
                ar_opb = den_reg;
            end
            default:
            begin
                ar_cmd = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                    if (opcode == OP_COMMIT && !cnt_bad)
                    begin
                        state_next = S_CM_LOAD;
                    end
                    else if (opcode == OP_CONVERT && ready_reg && (in_rng || clamp_reg))
                    begin
                        state_next = S_CV_LOAD;
                    end
                end
            end
            S_CM_LOAD:  state_next = S_CM_CHECK;
            S_CM_CHECK:
            begin
                if (idx_reg == 5'd0)
                begin
                    state_next = S_CM_LOAD;
                end
                else if (dir_fail)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_CM_MUL;
                end
            end
            S_CM_MUL:
            begin
                if (ar_rsp.done)
                begin
                    state_next = (over || cm_last) ? S_RESULT : S_CM_LOAD;
                end
            end
            S_CV_LOAD:  state_next = S_CV_CHECK;
            S_CV_CHECK: state_next = (hit || cv_last) ? S_CV_LOAD0 : S_CV_LOAD;
            S_CV_LOAD0: state_next = S_CV_GET0;
            S_CV_GET0:  state_next = S_CV_MUL;
            S_CV_MUL:
            begin
                if (ar_rsp.done)
                begin
                    state_next = S_CV_DIV;
                end
            end
            S_CV_DIV:
            begin
                if (ar_rsp.done)
                begin
                    state_next = S_CV_ROUND;
                end
            end
            S_CV_ROUND: state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pcount_reg   <= 5'd2;
            clamp_reg    <= 1'b0;
            swap_cfg_reg <= 1'b0;
            ready_reg    <= 1'b0;
            rising_reg   <= 1'b0;
            cswap_reg    <= 1'b0;
            act_cnt_reg  <= 5'd0;
            ext_reg[0]   <= 32'sd0;
            ext_reg[1]   <= 32'sd0;
            ext_reg[2]   <= 32'sd0;
            ext_reg[3]   <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINT_COUNT: pcount_reg   <= cfg_data;
                    CFG_CLAMP_ENDS:  clamp_reg    <= cfg_data[0];
                    CFG_SWAP_AXES:   swap_cfg_reg <= cfg_data[0];
                    default:         pcount_reg   <= pcount_reg;
                endcase
            end
            if (accept && (opcode == OP_WRITE || opcode == OP_COMMIT))
            begin
                ready_reg <= 1'b0;
            end
            if (state_reg == S_CM_MUL && ar_rsp.done && !over && cm_last)
            begin
                ext_reg[0]  <= up_reg ? fax_reg : pax_reg;
                ext_reg[1]  <= up_reg ? pax_reg : fax_reg;
                ext_reg[2]  <= mn_reg;
                ext_reg[3]  <= mx_reg;
                rising_reg  <= up_reg;
                act_cnt_reg <= cnt_reg;
                cswap_reg   <= swap_cfg_reg;
                ready_reg   <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_reg    <= ST_OK;
                    val_reg   <= 32'sd0;
                    seg_reg   <= 4'd0;
                    indom_reg <= 1'b0;
                    cnt_reg   <= pcount_reg;
                    case (opcode)
                        OP_WRITE:
                        begin
                            idx_reg <= 5'd0;
                        end
                        OP_COMMIT:
                        begin
                            idx_reg <= 5'd0;
                            if (cnt_bad)
                            begin
                                st_reg <= ST_INVALID;
                            end
                        end
                        OP_CONVERT:
                        begin
                            idx_reg <= 5'd1;
                            s_reg   <= in_rng ? sample
                                       : ((sample < ext_reg[0]) ? ext_reg[0] : ext_reg[1]);
                            if (!ready_reg)
                            begin
                                st_reg <= ST_NOT_READY;
                            end
                            else if (in_rng)
                            begin
                                indom_reg <= 1'b1;
                            end
                            else if (!clamp_reg)
                            begin
                                st_reg <= ST_RANGE;
                            end
                        end
                        default:
                        begin
                            st_reg <= ST_INVALID;
                        end
                    endcase
                end
            end
            S_CM_CHECK:
            begin
                pax_reg <= ax;
                pay_reg <= ay;
                if (idx_reg == 5'd0)
                begin
                    fax_reg <= ax;
                    mn_reg  <= ay;
                    mx_reg  <= ay;
                    idx_reg <= 5'd1;
                end
                else if (dir_fail)
                begin
                    st_reg <= ST_INVALID;
                end
                else
                begin
                    up_reg <= up_eff;
                    if (ay < mn_reg)
                    begin
                        mn_reg <= ay;
                    end
                    if (ay > mx_reg)
                    begin
                        mx_reg <= ay;
                    end
                end
            end
            S_CM_MUL:
            begin
                if (ar_rsp.done)
                begin
                    if (over)
                    begin
                        st_reg <= ST_OVERFLOW;
                    end
                    else if (!cm_last)
                    begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
            end
            S_CV_CHECK:
            begin
                if (hit || cv_last)
                begin
                    ax1_reg <= ax;
                    ay1_reg <= ay;
                    idx_reg <= idx_reg - 5'd1;
                end
                else
                begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
            S_CV_GET0:
            begin
                ay0_reg <= ay;
                neg_reg <= a_d[32] ^ dy0[32] ^ den_d[32];
                den_reg <= mag33(den_d);
                seg_reg <= idx_reg[3:0];
            end
            S_CV_DIV:
            begin
                if (ar_rsp.done)
                begin
                    qm_reg <= ar_lo[31:0] + {31'd0, inc};
                end
            end
            S_CV_ROUND:
            begin
                val_reg <= ay0_reg + (neg_reg ? -$signed(qm_reg) : $signed(qm_reg));
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    assign out_valid   = (state_reg == S_RESULT);
    assign status      = st_reg;
    assign value       = val_reg;
    assign segment     = seg_reg;
    assign in_domain   = indom_reg;
    assign rising      = ready_reg & rising_reg;
    assign domain_low  = ready_reg ? ext_reg[0] : 32'sd0;
    assign domain_high = ready_reg ? ext_reg[1] : 32'sd0;
    assign range_low   = ready_reg ? ext_reg[2] : 32'sd0;
    assign range_high  = ready_reg ? ext_reg[3] : 32'sd0;

endmodule
